// ===== src/eqd_pkg.sv =====
// ============================================================================
// eqd_pkg
// Shared types, constants and codes for the event queue dispatcher: item
// layouts, operation and status codes, and the controller/datapath interface.
// ============================================================================
package eqd_pkg;

  // sizing
  localparam int QUEUE_DEPTH = 128;
  localparam int SUBSCRIBERS = 32;
  localparam int QW          = $clog2(QUEUE_DEPTH);
  localparam int SUB_W       = $clog2(SUBSCRIBERS);
  localparam int SLOT_W      = 5;
  localparam int RES_W       = 5;
  localparam int CMP_W       = ((SUB_W > SLOT_W) ? SUB_W : SLOT_W) + 1;
  localparam logic [CMP_W-1:0] SUB_LIMIT = CMP_W'(SUBSCRIBERS);

  // operation codes
  typedef enum logic [2:0] {
    OP_APPEND    = 3'd0,
    OP_PUSH      = 3'd1,
    OP_DISPATCH  = 3'd2,
    OP_SUBSCRIBE = 3'd3,
    OP_CLAIM     = 3'd4,
    OP_UNSUB     = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_NOSLOT = 3'd3,
    ST_NOTRES = 3'd4
  } status_e;

  // input beat
  typedef struct packed {
    logic [2:0]        op;
    logic [15:0]       event_id;
    logic [15:0]       tag;
    logic              to_all;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  // output beat
  typedef struct packed {
    logic [2:0]        status;
    logic              delivered;
    logic [SLOT_W-1:0] subscriber;
    logic [15:0]       receiver;
    logic [15:0]       event_out;
    logic [15:0]       payload_out;
    logic              last;
  } out_item_t;

  // one queued event
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              to_all;
    logic [15:0]       tag;
    logic [15:0]       event_id;
  } ev_entry_t;

  // kind of result loaded into the output register
  typedef enum logic [1:0] {
    RK_STAT  = 2'd0,
    RK_GRANT = 2'd1,
    RK_DLV   = 2'd2
  } res_kind_e;

  // slot index register update
  typedef enum logic [2:0] {
    IX_HOLD  = 3'd0,
    IX_ZERO  = 3'd1,
    IX_DST   = 3'd2,
    IX_SLOT  = 3'd3,
    IX_START = 3'd4,
    IX_STEP  = 3'd5,
    IX_INC   = 3'd6
  } idx_op_e;

  // commands from controller to datapath
  typedef struct packed {
    logic      take_item;
    logic      q_append;
    logic      q_push;
    logic      q_pop;
    idx_op_e   idx_op;
    logic      rd_rcv;
    logic      grant;
    logic      grant_at_slot;
    logic      nf_update;
    logic      unsub;
    logic      out_load;
    res_kind_e out_kind;
    status_e   out_status;
    logic      out_last;
  } eqd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_e  op;
    logic full_tail;
    logic full_head;
    logic empty;
    logic no_room;
    logic claim_bad;
    logic ev_all;
    logic dst_live;
    logic any_alive;
    logic idx_alive;
    logic more_above;
    logic search_end;
    logic out_free;
  } eqd_sts_t;

endpackage

// ===== src/event_queue_dispatcher.sv =====
// ============================================================================
// event_queue_dispatcher
// Event mailbox: ring queue of events with append and urgent push, a
// subscriber table with subscribe, claim and unsubscribe, and dispatch that
// pops the head event and delivers it to one slot or every live slot.
// ============================================================================
//
//  channel | signals                      | beat
//  --------+------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data  | one operation
//  out     | out_valid, out_ready, out_data | one result (last marks end)
//  cfg     | cfg_we, cfg_data             | reserved slot count
//
//  One operation at a time; the next beat is taken the cycle after the last
//  result loads. Queue, claim, unsubscribe, spare ops and an empty dispatch
//  load their result after decode; dispatch to one slot or nobody waits for
//  the popped event first, as does a broadcast, which then scans from slot 0
//  to the last live slot, skipping empty slots and emitting each delivery.
//  Subscribe steps once per occupied slot passed. Reset is immediate: no
//  clearing pass. A stalled output register holds the controller in place.
//
module event_queue_dispatcher import eqd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [RES_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  eqd_cmd_t cmd;
  eqd_sts_t sts;

  // sequencing
  eqd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // storage and result formatting
  eqd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== src/eqd_ram.sv =====
// ============================================================================
// eqd_ram
// Generic single-write, single-read RAM with registered read data that holds
// while no read is requested.
// ============================================================================
module eqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/eqd_datapath.sv =====
// ============================================================================
// eqd_datapath
// Event ring, subscriber table, slot index/search counter and output register
// of the dispatcher; acts on commands from the controller.
// ============================================================================
module eqd_datapath import eqd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [RES_W-1:0] cfg_data,
  input  in_item_t         in_data,
  input  eqd_cmd_t         cmd,
  input  logic             out_ready,
  output eqd_sts_t         sts,
  output logic             out_valid,
  output out_item_t        out_data
);

  in_item_t             item;
  logic [QW-1:0]        head;
  logic [QW-1:0]        tail;
  logic [QW-1:0]        head_dec;
  logic [QW-1:0]        head_inc;
  logic [QW-1:0]        tail_inc;
  logic [SUBSCRIBERS-1:0] alive;
  logic [SUBSCRIBERS-1:0] above;
  logic [RES_W-1:0]     reserved;
  logic [RES_W-1:0]     next_free;
  logic [SUB_W-1:0]     sidx;
  logic [SUB_W-1:0]     sidx_next;
  logic [CMP_W-1:0]     kcnt;
  logic [CMP_W-1:0]     kcnt_next;
  logic [CMP_W-1:0]     sidx_up;
  logic [CMP_W-1:0]     span_m1;
  logic [SUB_W-1:0]     wrap_idx;
  logic [SUB_W-1:0]     start_idx;
  logic [SUB_W-1:0]     slot_idx;
  logic [SUB_W-1:0]     dst_idx;
  logic [SUB_W-1:0]     grant_addr;
  logic [SUB_W-1:0]     rcv_raddr;
  logic                 slot_ok;
  logic                 dst_ok;
  logic                 nf_ok;
  logic                 ev_we;
  logic [QW-1:0]        ev_waddr;
  ev_entry_t            ev_wdata;
  logic [$bits(ev_entry_t)-1:0] ev_rbits;
  ev_entry_t            ev;
  logic [15:0]          rcv_rdata;
  out_item_t            out_next;

  // ring pointer arithmetic
  assign head_inc = (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + QW'(1);
  assign head_dec = (head == '0) ? QW'(QUEUE_DEPTH - 1) : head - QW'(1);
  assign tail_inc = (tail == QW'(QUEUE_DEPTH - 1)) ? '0 : tail + QW'(1);

  // event store
  assign ev_we    = cmd.q_append | cmd.q_push;
  assign ev_waddr = cmd.q_push ? head_dec : tail;
  assign ev_wdata = '{slot: item.slot, to_all: item.to_all, tag: item.tag,
                      event_id: item.event_id};
  assign ev       = ev_entry_t'(ev_rbits);

  eqd_ram #(
    .WIDTH ($bits(ev_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ev_ram (
    .clk   (clk),
    .we    (ev_we),
    .waddr (ev_waddr),
    .wdata (ev_wdata),
    .re    (cmd.q_pop),
    .raddr (head),
    .rdata (ev_rbits)
  );

  // slot range checks and search helpers
  assign slot_idx  = SUB_W'(item.slot);
  assign dst_idx   = SUB_W'(ev.slot);
  assign slot_ok   = CMP_W'(item.slot) < SUB_LIMIT;
  assign dst_ok    = CMP_W'(ev.slot) < SUB_LIMIT;
  assign sidx_up   = CMP_W'(sidx) + CMP_W'(1);
  assign wrap_idx  = (sidx_up < SUB_LIMIT) ? SUB_W'(sidx_up) : SUB_W'(reserved);
  assign nf_ok     = (next_free >= reserved) && (CMP_W'(next_free) < SUB_LIMIT);
  assign start_idx = nf_ok ? SUB_W'(next_free) : SUB_W'(reserved);
  assign span_m1   = SUB_LIMIT - CMP_W'(1) - CMP_W'(reserved);
  assign above     = alive >> sidx;

  // receiver store
  assign grant_addr = cmd.grant_at_slot ? slot_idx : sidx;
  assign rcv_raddr  = (cmd.idx_op == IX_DST) ? dst_idx : sidx;

  eqd_ram #(
    .WIDTH (16),
    .DEPTH (SUBSCRIBERS)
  ) u_rcv_ram (
    .clk   (clk),
    .we    (cmd.grant),
    .waddr (grant_addr),
    .wdata (item.tag),
    .re    (cmd.rd_rcv),
    .raddr (rcv_raddr),
    .rdata (rcv_rdata)
  );

  // status toward the controller
  always_comb begin
    sts.op         = op_e'(item.op);
    sts.full_tail  = tail_inc == head;
    sts.full_head  = head_dec == tail;
    sts.empty      = head == tail;
    sts.no_room    = CMP_W'(reserved) >= SUB_LIMIT;
    sts.claim_bad  = (CMP_W'(item.slot) >= CMP_W'(reserved)) || !slot_ok;
    sts.ev_all     = ev.to_all;
    sts.dst_live   = dst_ok && alive[dst_idx];
    sts.any_alive  = |alive;
    sts.idx_alive  = alive[sidx];
    sts.more_above = |above[SUBSCRIBERS-1:1];
    sts.search_end = kcnt == span_m1;
    sts.out_free   = !out_valid || out_ready;
  end

  // input beat holding register
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item <= in_data;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (cmd.q_append) tail <= tail_inc;
      if (cmd.q_push)   head <= head_dec;
      if (cmd.q_pop)    head <= head_inc;
    end
  end

  // alive bits
  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= '0;
    end else begin
      if (cmd.grant)             alive[grant_addr] <= 1'b1;
      if (cmd.unsub && slot_ok)  alive[slot_idx]   <= 1'b0;
    end
  end

  // reserved count and free-slot hint
  always_ff @(posedge clk) begin
    if (rst) begin
      reserved  <= '0;
      next_free <= '0;
    end else if (cfg_we) begin
      reserved  <= cfg_data;
      next_free <= cfg_data;
    end else if (cmd.nf_update) begin
      next_free <= RES_W'(wrap_idx);
    end
  end

  // slot index and search step count
  always_comb begin
    sidx_next = sidx;
    kcnt_next = kcnt;
    case (cmd.idx_op)
      IX_HOLD:  ;
      IX_ZERO:  sidx_next = '0;
      IX_DST:   sidx_next = dst_idx;
      IX_SLOT:  sidx_next = slot_idx;
      IX_START: begin
        sidx_next = start_idx;
        kcnt_next = '0;
      end
      IX_STEP: begin
        sidx_next = wrap_idx;
        kcnt_next = kcnt + CMP_W'(1);
      end
      IX_INC:   sidx_next = SUB_W'(sidx_up);
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    sidx <= sidx_next;
    kcnt <= kcnt_next;
  end

  // result formatting
  always_comb begin
    out_next = '0;
    case (cmd.out_kind)
      RK_STAT: begin
        out_next.status = cmd.out_status;
        out_next.last   = 1'b1;
      end
      RK_GRANT: begin
        out_next.status     = ST_OK;
        out_next.subscriber = SLOT_W'(sidx);
        out_next.receiver   = item.tag;
        out_next.last       = 1'b1;
      end
      RK_DLV: begin
        out_next.status      = ST_OK;
        out_next.delivered   = 1'b1;
        out_next.subscriber  = SLOT_W'(sidx);
        out_next.receiver    = rcv_rdata;
        out_next.event_out   = ev.event_id;
        out_next.payload_out = ev.tag;
        out_next.last        = cmd.out_last;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= out_next;
    end
  end

endmodule

// ===== src/eqd_ctrl.sv =====
// ============================================================================
// eqd_ctrl
// Controller state machine: decodes each input beat, sequences queue access,
// delivery scans and free-slot searches, and schedules result beats.
// ============================================================================
module eqd_ctrl import eqd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  eqd_sts_t sts,
  output logic     in_ready,
  output eqd_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_EVWAIT = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_EMIT   = 7'b0010000,
    S_SEARCH = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t    state;
  state_t    state_next;
  res_kind_e resp_kind;
  res_kind_e resp_kind_next;
  status_e   resp_status;
  status_e   resp_status_next;
  logic      single;
  logic      single_next;
  logic      dlv_last;

  assign in_ready = state == S_IDLE;
  assign dlv_last = single || !sts.more_above;

  // next state and commands
  always_comb begin
    state_next       = state;
    resp_kind_next   = resp_kind;
    resp_status_next = resp_status;
    single_next      = single;
    cmd              = '0;
    cmd.idx_op       = IX_HOLD;
    cmd.out_kind     = RK_STAT;
    cmd.out_status   = ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        resp_kind_next   = RK_STAT;
        resp_status_next = ST_OK;
        state_next       = S_RESP;
        case (sts.op)
          OP_APPEND: begin
            if (sts.full_tail) resp_status_next = ST_FULL;
            else               cmd.q_append     = 1'b1;
          end
          OP_PUSH: begin
            if (sts.full_head) resp_status_next = ST_FULL;
            else               cmd.q_push       = 1'b1;
          end
          OP_DISPATCH: begin
            if (sts.empty) begin
              resp_status_next = ST_EMPTY;
            end else begin
              cmd.q_pop  = 1'b1;
              state_next = S_EVWAIT;
            end
          end
          OP_SUBSCRIBE: begin
            if (sts.no_room) begin
              resp_status_next = ST_NOSLOT;
            end else begin
              cmd.idx_op = IX_START;
              state_next = S_SEARCH;
            end
          end
          OP_CLAIM: begin
            if (sts.claim_bad) begin
              resp_status_next = ST_NOTRES;
            end else begin
              cmd.idx_op        = IX_SLOT;
              cmd.grant         = 1'b1;
              cmd.grant_at_slot = 1'b1;
              resp_kind_next    = RK_GRANT;
            end
          end
          OP_UNSUB: cmd.unsub = 1'b1;
          default: ;
        endcase
      end
      // popped event is on the read port
      S_EVWAIT: begin
        resp_kind_next   = RK_STAT;
        resp_status_next = ST_OK;
        if (sts.ev_all) begin
          if (sts.any_alive) begin
            cmd.idx_op  = IX_ZERO;
            single_next = 1'b0;
            state_next  = S_SCAN;
          end else begin
            state_next = S_RESP;
          end
        end else if (sts.dst_live) begin
          cmd.idx_op  = IX_DST;
          cmd.rd_rcv  = 1'b1;
          single_next = 1'b1;
          state_next  = S_EMIT;
        end else begin
          state_next = S_RESP;
        end
      end
      // walk the table in slot order for a broadcast
      S_SCAN: begin
        if (sts.idx_alive) begin
          cmd.rd_rcv = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.idx_op = IX_INC;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = RK_DLV;
          cmd.out_last = dlv_last;
          if (dlv_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_op = IX_INC;
            state_next = S_SCAN;
          end
        end
      end
      // wrapping free-slot search above the reserved range
      S_SEARCH: begin
        if (!sts.idx_alive) begin
          cmd.grant      = 1'b1;
          cmd.nf_update  = 1'b1;
          resp_kind_next = RK_GRANT;
          state_next     = S_RESP;
        end else if (sts.search_end) begin
          resp_kind_next   = RK_STAT;
          resp_status_next = ST_NOSLOT;
          state_next       = S_RESP;
        end else begin
          cmd.idx_op = IX_STEP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_kind   = resp_kind;
          cmd.out_status = resp_status;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      resp_kind   <= RK_STAT;
      resp_status <= ST_OK;
      single      <= 1'b0;
    end else begin
      state       <= state_next;
      resp_kind   <= resp_kind_next;
      resp_status <= resp_status_next;
      single      <= single_next;
    end
  end

endmodule

// ===== tb/sv/event_queue_dispatcher_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// event_queue_dispatcher_tb
// Self-checking bench for the event mailbox. A clocked driver feeds operation
// beats from a backlog and a clocked monitor checks every result beat against
// a cycle-free model of the ring queue and subscriber table. The run covers a
// directed pass, random traffic under three pacing schemes and a full
// subscriber table broadcast, at several reserved counts.
// ============================================================================
module event_queue_dispatcher_tb;
  import eqd_pkg::*;

  // op codes the block answers without doing anything
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [RES_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;

  event_queue_dispatcher i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // model state: ring queue, subscriber table, reserved count
  ev_entry_t      ring_mem [QUEUE_DEPTH];
  int             ring_head = 0;
  int             ring_tail = 0;
  logic [SUBSCRIBERS-1:0] slot_live = '0;
  logic [15:0]    slot_rcv [SUBSCRIBERS];
  int             free_hint = 0;
  int             rsv_count = 0;

  in_item_t  op_backlog[$];
  out_item_t pending_results[$];

  int  snd_gap_pct = 0;
  int  rcv_gap_pct = 0;
  logic in_took = 1'b0;
  int  n_queued = 0;
  int  n_accepted = 0;
  int  n_results = 0;
  int  n_deliveries = 0;
  int  n_full = 0;
  int  n_settings = 0;
  int  n_errors = 0;

  function automatic out_item_t make_result(status_e st, logic dlv, int sub,
                                            logic [15:0] rcv, logic [15:0] ev,
                                            logic [15:0] pl, logic lst);
    out_item_t r;
    r.status      = st;
    r.delivered   = dlv;
    r.subscriber  = SLOT_W'(sub);
    r.receiver    = rcv;
    r.event_out   = ev;
    r.payload_out = pl;
    r.last        = lst;
    return r;
  endfunction

  // model of one operation: updates state and queues the results it causes
  task automatic predict_outcome(input in_item_t it);
    int        nxt;
    int        cand;
    int        span;
    int        k;
    bit        granted;
    ev_entry_t e;
    out_item_t burst[$];
    e.slot     = it.slot;
    e.to_all   = it.to_all;
    e.tag      = it.tag;
    e.event_id = it.event_id;
    case (it.op)
      OP_APPEND: begin
        nxt = (ring_tail + 1) % QUEUE_DEPTH;
        if (nxt == ring_head) begin
          pending_results.push_back(make_result(ST_FULL, 0, 0, 0, 0, 0, 1));
        end else begin
          ring_mem[ring_tail] = e;
          ring_tail = nxt;
          pending_results.push_back(make_result(ST_OK, 0, 0, 0, 0, 0, 1));
        end
      end
      OP_PUSH: begin
        nxt = (ring_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
        if (nxt == ring_tail) begin
          pending_results.push_back(make_result(ST_FULL, 0, 0, 0, 0, 0, 1));
        end else begin
          ring_head = nxt;
          ring_mem[ring_head] = e;
          pending_results.push_back(make_result(ST_OK, 0, 0, 0, 0, 0, 1));
        end
      end
      OP_DISPATCH: begin
        if (ring_head == ring_tail) begin
          pending_results.push_back(make_result(ST_EMPTY, 0, 0, 0, 0, 0, 1));
        end else begin
          e = ring_mem[ring_head];
          ring_head = (ring_head + 1) % QUEUE_DEPTH;
          // broadcast walks the table in slot order
          if (e.to_all) begin
            for (k = 0; k < SUBSCRIBERS; k++) begin
              if (slot_live[k])
                burst.push_back(make_result(ST_OK, 1, k, slot_rcv[k], e.event_id,
                                            e.tag, 0));
            end
          end else if (int'(e.slot) < SUBSCRIBERS && slot_live[e.slot]) begin
            burst.push_back(make_result(ST_OK, 1, e.slot, slot_rcv[e.slot],
                                        e.event_id, e.tag, 0));
          end
          if (burst.size() == 0) begin
            pending_results.push_back(make_result(ST_OK, 0, 0, 0, 0, 0, 1));
          end else begin
            burst[burst.size()-1].last = 1'b1;
            foreach (burst[i]) pending_results.push_back(burst[i]);
          end
        end
      end
      OP_SUBSCRIBE: begin
        granted = 0;
        if (rsv_count < SUBSCRIBERS) begin
          span = SUBSCRIBERS - rsv_count;
          cand = (free_hint >= rsv_count && free_hint < SUBSCRIBERS) ? free_hint
                                                                     : rsv_count;
          // search upward from the hint, wrapping to the reserved count
          for (k = 0; k < span; k++) begin
            if (!slot_live[cand]) begin
              granted = 1;
              break;
            end
            cand = (cand + 1 < SUBSCRIBERS) ? cand + 1 : rsv_count;
          end
        end
        if (granted) begin
          slot_live[cand] = 1'b1;
          slot_rcv[cand]  = it.tag;
          free_hint = (cand + 1 < SUBSCRIBERS) ? cand + 1 : rsv_count;
          pending_results.push_back(make_result(ST_OK, 0, cand, it.tag, 0, 0, 1));
        end else begin
          pending_results.push_back(make_result(ST_NOSLOT, 0, 0, 0, 0, 0, 1));
        end
      end
      OP_CLAIM: begin
        if (int'(it.slot) >= rsv_count || int'(it.slot) >= SUBSCRIBERS) begin
          pending_results.push_back(make_result(ST_NOTRES, 0, 0, 0, 0, 0, 1));
        end else begin
          slot_live[it.slot] = 1'b1;
          slot_rcv[it.slot]  = it.tag;
          pending_results.push_back(make_result(ST_OK, 0, it.slot, it.tag, 0, 0, 1));
        end
      end
      OP_UNSUB: begin
        if (int'(it.slot) < SUBSCRIBERS) slot_live[it.slot] = 1'b0;
        pending_results.push_back(make_result(ST_OK, 0, 0, 0, 0, 0, 1));
      end
      default: begin
        pending_results.push_back(make_result(ST_OK, 0, 0, 0, 0, 0, 1));
      end
    endcase
  endtask

  task automatic report_field(string fname, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, fname, want, got);
      n_errors++;
    end
  endtask

  // input driver: a new beat only after the previous one was taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (op_backlog.size() != 0 && $urandom_range(99) >= snd_gap_pct) begin
        in_data  <= op_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= rcv_gap_pct);
  end

  // monitor: check result beats, then model accepted operation beats
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      in_took = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $display("%0t ns: result beat with none expected, got %p", $time, out_data);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.delivered === 1'b1) n_deliveries++;
          if (out_data.status === ST_FULL) n_full++;
          report_field("status", want.status, out_data.status);
          report_field("delivered", want.delivered, out_data.delivered);
          report_field("subscriber", want.subscriber, out_data.subscriber);
          report_field("receiver", want.receiver, out_data.receiver);
          report_field("event_out", want.event_out, out_data.event_out);
          report_field("payload_out", want.payload_out, out_data.payload_out);
          report_field("last", want.last, out_data.last);
        end
      end
      in_took = in_valid && in_ready;
      if (in_took) begin
        n_accepted++;
        predict_outcome(in_data);
      end
    end
  end

  function automatic in_item_t mk_op(logic [2:0] op, logic [15:0] id, logic [15:0] tg,
                                     logic all, logic [SLOT_W-1:0] sl);
    in_item_t it;
    it.op       = op;
    it.event_id = id;
    it.tag      = tg;
    it.to_all   = all;
    it.slot     = sl;
    return it;
  endfunction

  task automatic enqueue(input in_item_t it);
    op_backlog.push_back(it);
    n_queued++;
  endtask

  // random operation, mostly well formed for the current reserved count
  function automatic in_item_t random_op();
    in_item_t it;
    int       pick;
    pick = $urandom_range(99);
    it.event_id = 16'($urandom);
    it.tag      = 16'($urandom);
    it.to_all   = ($urandom_range(9) < 4);
    it.slot     = SLOT_W'($urandom_range(31));
    if (pick < 22)      it.op = OP_APPEND;
    else if (pick < 32) it.op = OP_PUSH;
    else if (pick < 57) it.op = OP_DISPATCH;
    else if (pick < 70) it.op = OP_SUBSCRIBE;
    else if (pick < 84) it.op = OP_CLAIM;
    else if (pick < 95) it.op = OP_UNSUB;
    else                it.op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
    if (it.op == OP_CLAIM && rsv_count > 0 && $urandom_range(4) != 0)
      it.slot = SLOT_W'($urandom_range(rsv_count - 1));
    return it;
  endfunction

  // reserved count write while idle; the model hint follows the register
  task automatic set_reserved(int v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= RES_W'(v);
    @(negedge clk);
    cfg_we   <= 1'b0;
    rsv_count = v;
    free_hint = v;
    n_settings++;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (n_accepted != n_queued || pending_results.size() != 0);
  endtask

  // stimulus sequence
  initial begin
    int r;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed pass with four reserved slots
    snd_gap_pct = 14;
    rcv_gap_pct = 68;
    set_reserved(4);
    enqueue(mk_op(OP_DISPATCH,  16'h0000, 16'h0000, 1'b0, 5'd0));
    enqueue(mk_op(OP_APPEND,    16'hffff, 16'hffff, 1'b0, 5'd31));
    enqueue(mk_op(OP_DISPATCH,  16'h0000, 16'h0000, 1'b0, 5'd0));
    enqueue(mk_op(OP_CLAIM,     16'h0000, 16'hffff, 1'b0, 5'd3));
    enqueue(mk_op(OP_CLAIM,     16'h0000, 16'h1111, 1'b0, 5'd4));
    enqueue(mk_op(OP_CLAIM,     16'h0000, 16'h0000, 1'b1, 5'd31));
    enqueue(mk_op(OP_CLAIM,     16'hffff, 16'h0000, 1'b0, 5'd0));
    enqueue(mk_op(OP_SUBSCRIBE, 16'h0000, 16'haaaa, 1'b0, 5'd0));
    enqueue(mk_op(OP_SUBSCRIBE, 16'h0000, 16'h5555, 1'b0, 5'd0));
    enqueue(mk_op(OP_CLAIM,     16'h0000, 16'h1234, 1'b0, 5'd3));
    enqueue(mk_op(OP_APPEND,    16'h0000, 16'h0000, 1'b1, 5'd0));
    enqueue(mk_op(OP_PUSH,      16'hbeef, 16'h0001, 1'b0, 5'd4));
    enqueue(mk_op(OP_DISPATCH,  16'h0000, 16'h0000, 1'b0, 5'd0));
    enqueue(mk_op(OP_DISPATCH,  16'h0000, 16'h0000, 1'b0, 5'd0));
    enqueue(mk_op(OP_UNSUB,     16'h0000, 16'h0000, 1'b0, 5'd4));
    enqueue(mk_op(OP_UNSUB,     16'h0000, 16'h0000, 1'b0, 5'd31));
    enqueue(mk_op(OP_APPEND,    16'h1234, 16'h4321, 1'b0, 5'd4));
    enqueue(mk_op(OP_DISPATCH,  16'h0000, 16'h0000, 1'b0, 5'd0));
    enqueue(mk_op(OP_SPARE_6,   16'hffff, 16'hffff, 1'b1, 5'd31));
    enqueue(mk_op(OP_SPARE_7,   16'h0000, 16'h0000, 1'b0, 5'd0));
    enqueue(mk_op(OP_SUBSCRIBE, 16'h0000, 16'hffff, 1'b0, 5'd0));
    enqueue(mk_op(OP_PUSH,      16'h8000, 16'h7fff, 1'b1, 5'd31));
    enqueue(mk_op(OP_DISPATCH,  16'h0000, 16'h0000, 1'b0, 5'd0));
    wait_drained();

    // random traffic, no reserved slots
    set_reserved(0);
    repeat (25) enqueue(random_op());
    wait_drained();

    // random traffic, all but the top slot reserved, pacing swapped
    snd_gap_pct = 68;
    rcv_gap_pct = 14;
    set_reserved(31);
    repeat (25) enqueue(random_op());
    wait_drained();

    // full pace: fill the table, broadcast to all, then random traffic
    snd_gap_pct = 0;
    rcv_gap_pct = 0;
    r = $urandom_range(1, 30);
    set_reserved(r);
    for (int s = 0; s < r; s++)
      enqueue(mk_op(OP_CLAIM, 16'($urandom), 16'($urandom), 1'($urandom), SLOT_W'(s)));
    repeat (SUBSCRIBERS - r + 1)
      enqueue(mk_op(OP_SUBSCRIBE, 16'($urandom), 16'($urandom), 1'($urandom),
                    SLOT_W'($urandom)));
    enqueue(mk_op(OP_PUSH, 16'($urandom), 16'($urandom), 1'b1, SLOT_W'($urandom)));
    enqueue(mk_op(OP_DISPATCH, 16'($urandom), 16'($urandom), 1'($urandom),
                  SLOT_W'($urandom)));
    repeat (12) enqueue(random_op());
    wait_drained();

    // let any stray beat show up
    repeat (128) @(posedge clk);
    $display("covered %0d operations and %0d result beats over %0d reserved counts",
             n_accepted, n_results, n_settings);
    $display("seen %0d deliveries and %0d queue-full answers", n_deliveries, n_full);
    if (n_errors == 0)
      $display("event_queue_dispatcher_tb: clean");
    else
      $display("event_queue_dispatcher_tb: errors");
    $finish;
  end

  // watchdog
  initial begin
    #(10_000_000);
    $display("%0t ns: timeout with %0d result beats outstanding", $time,
             pending_results.size());
    $display("event_queue_dispatcher_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
src/eqd_pkg.sv
src/eqd_ram.sv
src/eqd_datapath.sv
src/eqd_ctrl.sv
src/event_queue_dispatcher.sv
tb/sv/event_queue_dispatcher_tb.sv
